@@ rtl/core/checked_integer_alu_defines.svh @@
// assertion macros for the checked integer alu
`ifndef CHECKED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_INTEGER_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("checked_integer_alu assertion failed");
`define CIA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("checked_integer_alu assertion failed");
`else
`define CIA_ASSERT(lbl, prop)
`define CIA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/core/cia_pkg.sv @@
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and constants of the checked integer alu pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cia_pkg;

  typedef enum logic [3:0] {
    K_ADD = 4'd0, K_SUB = 4'd1, K_MUL = 4'd2, K_DIV = 4'd3, K_REM = 4'd4,
    K_EQ = 4'd5, K_NE = 4'd6, K_LT = 4'd7, K_LE = 4'd8, K_GT = 4'd9,
    K_GE = 4'd10, K_NEG = 4'd11, K_NOT = 4'd12
  } kind_t;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_TYPE = 3'd1;
  localparam logic [2:0] ST_OVF  = 3'd2;
  localparam logic [2:0] ST_DIV0 = 3'd3;
  localparam logic [2:0] ST_REM0 = 3'd4;

  localparam logic [63:0] INT_MIN = 64'h8000_0000_0000_0000;

  // one divider iteration per stage, plus decode and output stages
  localparam int DIV_STAGES = 64;
  localparam int LAST       = DIV_STAGES + 1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  st;
    logic [63:0] val;
    logic        isb;
    logic        neg;
    logic        rneg;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } stage_t;

endpackage
`default_nettype wire

@@ rtl/core/checked_integer_alu.sv @@
// ----------------------------------------------------------------------------
// checked_integer_alu
// 64-bit Int/Bool alu with type, overflow and zero divisor checking.
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless the pipe is full and out_ready is low; stages hold independently on stall
// the pipeline depth is set by the 64-stage restoring divider, one quotient bit
// per stage; the multiplier uses four 32x32 products over two stages
// reset clears all stage valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "checked_integer_alu_defines.svh"
module checked_integer_alu
  import cia_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         kind,
  input  wire logic signed [63:0] left_value,
  input  wire logic               left_is_bool,
  input  wire logic signed [63:0] right_value,
  input  wire logic               right_is_bool,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      result_value,
  output logic                    result_is_bool,
  output logic [2:0]              status
);

  stage_t       pipe [0:LAST];
  stage_t       nxt  [0:LAST];
  logic [LAST:0] v;
  logic [LAST:0] en;

  // one restoring division step
  function automatic stage_t div_step(input stage_t s);
    stage_t      r;
    logic [63:0] sh;
    logic        ge;
    r  = s;
    sh = {s.rem[62:0], s.quo[63]};
    ge = (sh >= s.dvs);
    r.rem = ge ? (sh - s.dvs) : sh;
    r.quo = {s.quo[62:0], ge};
    return r;
  endfunction

  // decode, type checks and the short operations
  always_comb begin
    logic [63:0] a, b, sum, dif;
    logic        ints, eqv, lt, gt;
    a    = left_value;
    b    = right_value;
    ints = !left_is_bool && !right_is_bool;
    sum  = a + b;
    dif  = a - b;
    lt   = (left_value < right_value);
    gt   = (right_value < left_value);
    eqv  = 1'b0;
    nxt[0]      = '0;
    nxt[0].kind = kind;
    nxt[0].st   = ST_OK;
    nxt[0].neg  = (a[63] ^ b[63]) && (a != '0) && (b != '0);
    nxt[0].rneg = a[63];
    nxt[0].quo  = a[63] ? (64'd0 - a) : a;
    nxt[0].dvs  = b[63] ? (64'd0 - b) : b;
    case (kind_t'(kind))
      K_ADD: begin
        if (!ints) nxt[0].st = ST_TYPE;
        else begin
          nxt[0].val = sum;
          if (((a ^ sum) & (b ^ sum) & INT_MIN) != '0) nxt[0].st = ST_OVF;
        end
      end
      K_SUB: begin
        if (!ints) nxt[0].st = ST_TYPE;
        else begin
          nxt[0].val = dif;
          if (((a ^ b) & (a ^ dif) & INT_MIN) != '0) nxt[0].st = ST_OVF;
        end
      end
      K_MUL: begin
        if (!ints) nxt[0].st = ST_TYPE;
      end
      K_DIV, K_REM: begin
        if (!ints) nxt[0].st = ST_TYPE;
        else if (b == '0) nxt[0].st = (kind_t'(kind) == K_DIV) ? ST_DIV0 : ST_REM0;
        else if (a == INT_MIN && b == '1) nxt[0].st = ST_OVF;
      end
      K_EQ, K_NE: begin
        if (ints) eqv = (a == b);
        else if (left_is_bool && right_is_bool) eqv = ((a != '0) == (b != '0));
        else nxt[0].st = ST_TYPE;
        nxt[0].val = {63'd0, (kind_t'(kind) == K_EQ) ? eqv : !eqv};
        nxt[0].isb = 1'b1;
      end
      K_LT, K_LE, K_GT, K_GE: begin
        if (!ints) nxt[0].st = ST_TYPE;
        case (kind_t'(kind))
          K_LT:    nxt[0].val = {63'd0, lt};
          K_LE:    nxt[0].val = {63'd0, !gt};
          K_GT:    nxt[0].val = {63'd0, gt};
          default: nxt[0].val = {63'd0, !lt};
        endcase
        nxt[0].isb = 1'b1;
      end
      K_NEG: begin
        if (left_is_bool) nxt[0].st = ST_TYPE;
        else if (a == INT_MIN) nxt[0].st = ST_OVF;
        else nxt[0].val = 64'd0 - a;
      end
      K_NOT: begin
        if (!left_is_bool) nxt[0].st = ST_TYPE;
        nxt[0].val = {63'd0, (a == '0)};
        nxt[0].isb = 1'b1;
      end
      default: nxt[0].st = ST_TYPE;
    endcase
  end

  // divider stages, with the multiplier folded into the first two
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_comb begin
      logic [63:0]  mid, lo, hi;
      logic         ovf;
      nxt[k] = div_step(pipe[k-1]);
      mid = '0;
      lo  = '0;
      hi  = '0;
      ovf = 1'b0;
      if (k == 1) begin
        nxt[k].p00 = {32'd0, pipe[k-1].quo[31:0]}  * {32'd0, pipe[k-1].dvs[31:0]};
        nxt[k].p01 = {32'd0, pipe[k-1].quo[31:0]}  * {32'd0, pipe[k-1].dvs[63:32]};
        nxt[k].p10 = {32'd0, pipe[k-1].quo[63:32]} * {32'd0, pipe[k-1].dvs[31:0]};
        nxt[k].p11 = {32'd0, pipe[k-1].quo[63:32]} * {32'd0, pipe[k-1].dvs[63:32]};
      end
      if (k == 2) begin
        mid = {32'd0, pipe[k-1].p00[63:32]} + {32'd0, pipe[k-1].p01[31:0]}
            + {32'd0, pipe[k-1].p10[31:0]};
        lo  = {mid[31:0], pipe[k-1].p00[31:0]};
        hi  = pipe[k-1].p11 + {32'd0, pipe[k-1].p01[63:32]}
            + {32'd0, pipe[k-1].p10[63:32]} + {32'd0, mid[63:32]};
        ovf = (hi != '0) || (pipe[k-1].neg ? (lo > INT_MIN) : (lo >= INT_MIN));
        if (kind_t'(pipe[k-1].kind) == K_MUL && pipe[k-1].st == ST_OK) begin
          if (ovf) nxt[k].st = ST_OVF;
          else nxt[k].val = lo;
        end
      end
    end
  end

  // sign fixup and error zeroing
  always_comb begin
    nxt[LAST] = pipe[LAST-1];
    case (kind_t'(pipe[LAST-1].kind))
      K_MUL: nxt[LAST].val = pipe[LAST-1].neg ? (64'd0 - pipe[LAST-1].val) : pipe[LAST-1].val;
      K_DIV: nxt[LAST].val = pipe[LAST-1].neg ? (64'd0 - pipe[LAST-1].quo) : pipe[LAST-1].quo;
      K_REM: nxt[LAST].val = pipe[LAST-1].rneg ? (64'd0 - pipe[LAST-1].rem) : pipe[LAST-1].rem;
      default: nxt[LAST].val = pipe[LAST-1].val;
    endcase
    if (pipe[LAST-1].st != ST_OK) begin
      nxt[LAST].val = '0;
      nxt[LAST].isb = 1'b0;
    end
  end

  // per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[LAST] = !v[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  // stage registers
  for (genvar k = 0; k <= LAST; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en[k]) pipe[k] <= nxt[k];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = v[LAST];
  assign result_value   = pipe[LAST].val;
  assign result_is_bool = pipe[LAST].isb;
  assign status         = pipe[LAST].st;

  `CIA_ASSERT(a_err_zero, (out_valid && status != ST_OK) |-> (result_value == '0 && !result_is_bool))
  `CIA_ASSERT(a_bool_bit, (out_valid && result_is_bool) |-> (result_value[63:1] == '0))
  `CIA_ASSERT(a_status_range, out_valid |-> (status <= ST_REM0))
  `CIA_ASSERT(a_full_stall, !in_ready |-> (v == '1 && !out_ready))
  `CIA_ASSERT_NEXT(a_drain, (out_valid && out_ready && !v[LAST-1]), !out_valid)

endmodule
`default_nettype wire
